[rtl/core/swmm_pkg.sv]
// Shared types for the sliding window min/max block.
// Used by swmm_cell and sliding_window_min_max; no dependencies.
package swmm_pkg;

  localparam int SAMPLE_W = 32;
  localparam int CFG_W    = 7;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // running min/max moving down the cell row
  typedef struct packed {
    logic    valid;
    sample_t min_val;
    sample_t max_val;
  } token_t;

endpackage

[rtl/core/sliding_window_min_max.sv]
// Sliding window min/max: top level with the cell row and output buffering.
// Depends on swmm_pkg and swmm_cell.
// Result path: start register, then the token register of every cell, then the
// output register. An item that yields a result holds off further items until
// its min/max token, walking the cell row one cell per cycle, has left the row;
// other items are taken every cycle while no token walks and the skid is free.
// Reset (rst, sync, active high): window_size = 1, window empty, no result.
module sliding_window_min_max
  import swmm_pkg::*;
#(
  parameter int WINDOW_MAX = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  // configuration: window_size
  input  logic                 cfg_we,
  input  logic [CFG_W-1:0]     cfg_data,
  // input items
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [SAMPLE_W-1:0]  s_tdata,   // [31:0] sample
  input  logic                 s_tuser,   // [0] restart
  // result items
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [2*SAMPLE_W-1:0] m_tdata   // [31:0] window_min, [63:32] window_max
);

  localparam int CW = $clog2(WINDOW_MAX + 1);
  localparam int EW = (CW > CFG_W) ? CW : CFG_W;

  // configuration register
  logic [CFG_W-1:0] window_size;
  logic [EW-1:0]    win_len;      // window_size clamped to 1..WINDOW_MAX

  // sequence bookkeeping
  logic [CW-1:0] fill_count;
  logic [CW-1:0] fill_base;
  logic [CW-1:0] fill_count_next;
  logic          produce;
  logic          accept;
  logic          busy;        // token in flight
  logic          start;       // launch token into cell 0

  // cell row
  sample_t cell_sample [WINDOW_MAX];
  token_t  cell_tok    [WINDOW_MAX];
  token_t  head_tok;
  logic [WINDOW_MAX-1:0] tok_valid_vec;
  logic    exit_valid;

  // output register and skid entry
  sample_t out_min;
  sample_t out_max;
  logic    skid_valid;
  sample_t skid_min;
  sample_t skid_max;
  logic    pop;

  always_comb begin
    if (window_size == '0) begin
      win_len = EW'(1);
    end else if (EW'(window_size) > EW'(WINDOW_MAX)) begin
      win_len = EW'(WINDOW_MAX);
    end else begin
      win_len = EW'(window_size);
    end
  end

  // Accept while no token walks the row and the skid entry is free; a
  // result waiting in the output register does not block new items.
  assign s_tready = !busy && !skid_valid;
  assign accept   = s_tvalid && s_tready;

  // restart empties the window before its own sample is counted
  assign fill_base       = s_tuser ? '0 : fill_count;
  assign fill_count_next = (fill_base < CW'(WINDOW_MAX)) ? fill_base + CW'(1) : fill_base;
  assign produce         = (EW'(fill_count_next) >= win_len);

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= CFG_W'(1);
      fill_count  <= '0;
      busy        <= 1'b0;
      start       <= 1'b0;
    end else begin
      if (cfg_we) begin
        window_size <= cfg_data;
      end
      start <= accept && produce;
      if (accept) begin
        fill_count <= fill_count_next;
      end
      if (accept && produce) begin
        busy <= 1'b1;
      end else if (exit_valid) begin
        busy <= 1'b0;
      end
    end
  end

  // Token enters cell 0 seeded with the newest sample, one cell per cycle.
  always_comb begin
    head_tok.valid   = start;
    head_tok.min_val = cell_sample[0];
    head_tok.max_val = cell_sample[0];
  end

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    sample_t s_in;
    token_t  t_in;
    if (i == 0) begin : g_head
      assign s_in = s_tdata;
      assign t_in = head_tok;
    end else begin : g_body
      assign s_in = cell_sample[i-1];
      assign t_in = cell_tok[i-1];
    end
    swmm_cell #(
      .INDEX (i),
      .EW    (EW)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .shift      (accept),
      .sample_in  (s_in),
      .sample_out (cell_sample[i]),
      .win_len    (win_len),
      .tok_in     (t_in),
      .tok_out    (cell_tok[i])
    );
    assign tok_valid_vec[i] = cell_tok[i].valid;
  end

  assign exit_valid = cell_tok[WINDOW_MAX-1].valid;

  // Output register plus one skid entry; skid only fills when the output
  // register is still held at the moment a token exits the row.
  assign pop = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (exit_valid) begin
        if (!m_tvalid || pop) begin
          m_tvalid <= 1'b1;
          out_min  <= cell_tok[WINDOW_MAX-1].min_val;
          out_max  <= cell_tok[WINDOW_MAX-1].max_val;
        end else begin
          skid_valid <= 1'b1;
          skid_min   <= cell_tok[WINDOW_MAX-1].min_val;
          skid_max   <= cell_tok[WINDOW_MAX-1].max_val;
        end
      end else if (pop) begin
        if (skid_valid) begin
          out_min    <= skid_min;
          out_max    <= skid_max;
          skid_valid <= 1'b0;
        end else begin
          m_tvalid <= 1'b0;
        end
      end
    end
  end

  assign m_tdata = {out_max, out_min};

  // at most one token in the row
  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $onehot0(tok_valid_vec))
    else $error("more than one token in the cell row");

  // a token only exits while the block counts itself busy
  a_exit_busy: assert property (@(posedge clk) disable iff (rst)
    exit_valid |-> busy)
    else $error("token exit without busy");

  // skid entry never holds data without the output register full
  a_skid_order: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_tvalid)
    else $error("skid valid while output register empty");

  // no exit can collide with a held skid entry
  a_skid_exit: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> !exit_valid && !busy)
    else $error("token in flight while skid entry full");

  // an accepted item that yields a result launches exactly one token
  a_launch: assert property (@(posedge clk) disable iff (rst)
    (accept && produce) |=> start && busy)
    else $error("result item did not launch a token");

endmodule

[rtl/core/swmm_cell.sv]
// One cell of the sample row: holds one sample and, inside the window, folds it into the passing token.
// Depends on swmm_pkg.
module swmm_cell
  import swmm_pkg::*;
#(
  parameter int INDEX = 0,
  parameter int EW    = 7
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          shift,
  input  sample_t       sample_in,
  output sample_t       sample_out,
  input  logic [EW-1:0] win_len,
  input  token_t        tok_in,
  output token_t        tok_out
);

  sample_t sample;
  token_t  tok;
  token_t  tok_next;
  logic    in_window;

  // cell INDEX holds the sample taken INDEX items ago
  assign in_window = (EW'(INDEX) < win_len);

  always_comb begin
    tok_next = tok_in;
    if (in_window && (sample < tok_in.min_val)) begin
      tok_next.min_val = sample;
    end
    if (in_window && (sample > tok_in.max_val)) begin
      tok_next.max_val = sample;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      sample <= sample_in;
    end
    if (rst) begin
      tok <= '0;
    end else begin
      tok <= tok_next;
    end
  end

  assign sample_out = sample;
  assign tok_out    = tok;

endmodule
